### hdl/salc_pkg.sv
// Shared types and constants for the set-associative LRU tag cache.
// No dependencies; imported by salc_row_update and set_assoc_lru_tag_cache.
package salc_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_SETS  = 256;
  localparam int DEF_MAX_WAYS  = 16;
  localparam int DEF_ADDR_BITS = 13;

  // Field widths of the item and configuration ports.
  localparam int FUNC_W     = 1;
  localparam int STATUS_W   = 2;
  localparam int SET_IDX_W  = 8;
  localparam int BS_W       = 3;
  localparam int WL_W       = 3;
  localparam int SL_W       = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Per-way LRU age, 0 is most recently used.
  localparam int            AGE_W   = 4;
  localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT_LOG2  = 2'd2;

  // Access kinds.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_STORE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORE     = 2'd0,
    ST_LOAD_HIT  = 2'd1,
    ST_LOAD_MISS = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_e;

endpackage

### hdl/salc_row_update.sv
// Combinational lookup and LRU update of one cache set (all ways of one row).
// Depends on salc_pkg for the age width and saturation value.
module salc_row_update #(
  parameter int NW    = 16,
  parameter int TAG_W = 13
) (
  input  logic [TAG_W-1:0]           tag_i,
  input  logic [NW-1:0]              inuse_i,
  input  logic [NW-1:0][TAG_W-1:0]   row_tag_i,
  input  logic [NW-1:0]              row_valid_i,
  input  logic [NW-1:0][salc_pkg::AGE_W-1:0] row_age_i,
  output logic                       hit_o,
  output logic [NW-1:0][TAG_W-1:0]   new_tag_o,
  output logic [NW-1:0]              new_valid_o,
  output logic [NW-1:0][salc_pkg::AGE_W-1:0] new_age_o
);
  import salc_pkg::*;

  logic [NW-1:0]    match;
  logic [NW-1:0]    hit_oh;
  logic [NW-1:0]    free_w;
  logic [NW-1:0]    free_oh;
  logic [NW-1:0]    cand;
  logic [NW-1:0]    evict_oh;
  logic [NW-1:0]    victim_oh;
  logic [AGE_W-1:0] hit_age;

  // Lowest-numbered matching way wins when duplicates exist.
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      match[w]  = inuse_i[w] & row_valid_i[w] & (row_tag_i[w] == tag_i);
      free_w[w] = inuse_i[w] & ~row_valid_i[w];
    end
  end

  assign hit_oh  = match & (~match + NW'(1));
  assign free_oh = free_w & (~free_w + NW'(1));
  assign hit_o   = |match;

  always_comb begin
    hit_age = '0;
    for (int w = 0; w < NW; w++) begin
      if (hit_oh[w]) begin
        hit_age = hit_age | row_age_i[w];
      end
    end
  end

  // A way in use is an eviction candidate when no in-use way is older; the lowest
  // candidate is the oldest way with the lowest index.
  always_comb begin
    logic ok;
    for (int w = 0; w < NW; w++) begin
      ok = inuse_i[w];
      for (int v = 0; v < NW; v++) begin
        if (inuse_i[v] && (row_age_i[v] > row_age_i[w])) begin
          ok = 1'b0;
        end
      end
      cand[w] = ok;
    end
  end

  assign evict_oh  = cand & (~cand + NW'(1));
  assign victim_oh = (|free_w) ? free_oh : evict_oh;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      new_tag_o[w]   = row_tag_i[w];
      new_valid_o[w] = row_valid_i[w];
      new_age_o[w]   = row_age_i[w];
      if (hit_o) begin
        if (hit_oh[w]) begin
          new_age_o[w] = '0;
        end else if (inuse_i[w] && row_valid_i[w] && (row_age_i[w] < hit_age)) begin
          new_age_o[w] = row_age_i[w] + AGE_W'(1);
        end
      end else begin
        if (victim_oh[w]) begin
          new_tag_o[w]   = tag_i;
          new_valid_o[w] = 1'b1;
          new_age_o[w]   = '0;
        end else if (inuse_i[w] && row_valid_i[w] && (row_age_i[w] < AGE_MAX)) begin
          new_age_o[w] = row_age_i[w] + AGE_W'(1);
        end
      end
    end
  end

endmodule

### hdl/set_assoc_lru_tag_cache.sv
// Top level of the tag-only set-associative cache with true LRU replacement.
// Depends on salc_pkg and salc_row_update; holds the set row memory.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o   | func_i, address_i
//   out     | output    | out_valid_o / out_stall_i | status_o, set_index_o
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// Each item first reads its set row from the row memory, then updates the
// row, writes it back and loads the output register.
// A new item is taken only once the previous one has left the update cycle.
// Reset needs no clearing pass: one flag per set marks rows never written,
// and such rows read as all ways invalid with age zero.
// A stalled output holds the item in the update cycle until the register frees.
module set_assoc_lru_tag_cache #(
  parameter int MAX_SETS  = salc_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [salc_pkg::FUNC_W-1:0]     func_i,
  input  logic [ADDR_BITS-1:0]            address_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [salc_pkg::STATUS_W-1:0]   status_o,
  output logic [salc_pkg::SET_IDX_W-1:0]  set_index_o
);
  import salc_pkg::*;

  localparam int SLG_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int WLG_MAX = $clog2(MAX_WAYS + 1) - 1;
  localparam int ROWS    = 2 ** SLG_MAX;
  localparam int NW      = 2 ** WLG_MAX;
  localparam int SA      = (SLG_MAX > 0) ? SLG_MAX : 1;
  localparam int TAG_W   = ADDR_BITS;
  localparam int BLK_W0  = (ADDR_BITS > SA) ? ADDR_BITS : SA;
  localparam int BLK_W   = (BLK_W0 > SET_IDX_W) ? BLK_W0 : SET_IDX_W;
  localparam int ROW_W   = NW * (TAG_W + 1 + AGE_W);
  localparam int NWC_W   = WLG_MAX + 2;

  // Configuration registers.
  logic [BS_W-1:0] bs_q;
  logic [WL_W-1:0] wl_q;
  logic [SL_W-1:0] sl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= '0;
      wl_q <= '0;
      sl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE_LOG2: bs_q <= cfg_data_i[BS_W-1:0];
        CFG_WAYS_LOG2:       wl_q <= cfg_data_i[WL_W-1:0];
        CFG_SET_COUNT_LOG2:  sl_q <= cfg_data_i[SL_W-1:0];
        default: ;
      endcase
    end
  end

  // Oversized settings fall back to the largest size the store holds.
  logic [SL_W-1:0]  slg;
  logic [WL_W-1:0]  wlg;
  logic [NWC_W-1:0] nways;
  logic [NW-1:0]    inuse;

  assign slg   = (sl_q > SL_W'(SLG_MAX)) ? SL_W'(SLG_MAX) : sl_q;
  assign wlg   = (wl_q > WL_W'(WLG_MAX)) ? WL_W'(WLG_MAX) : wl_q;
  assign nways = NWC_W'(1) << wlg;
  assign inuse = ~({NW{1'b1}} << nways);

  // Address split.
  logic [BLK_W-1:0] block;
  logic [BLK_W-1:0] set_full;
  logic [BLK_W-1:0] tag_full;

  assign block    = BLK_W'(address_i) >> bs_q;
  assign set_full = block & ~({BLK_W{1'b1}} << slg);
  assign tag_full = block >> slg;

  // Control.
  state_e state_q, state_d;
  logic   in_acc;
  logic   look_done;
  logic   out_valid_q;
  logic   rd_en;
  logic   wr_en;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign look_done = (state_q == S_LOOK) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
      end
      S_LOOK: begin
        wr_en = look_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item held through the update cycle.
  logic [FUNC_W-1:0]    func_q;
  logic [TAG_W-1:0]     tag_q;
  logic [SA-1:0]        set_q;
  logic [SET_IDX_W-1:0] set_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= func_i;
      tag_q     <= tag_full[TAG_W-1:0];
      set_q     <= set_full[SA-1:0];
      set_idx_q <= set_full[SET_IDX_W-1:0];
    end
  end

  // Set row memory, one row per set: ages, valid bits and tags of all ways.
  logic [ROW_W-1:0] row_mem [ROWS];
  logic [ROW_W-1:0] rd_row_q;
  logic [ROW_W-1:0] wr_row;
  logic [ROWS-1:0]  row_init_q;
  logic             rd_init_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= row_mem[set_full[SA-1:0]];
    end
    if (wr_en) begin
      row_mem[set_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
      rd_init_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_init_q <= row_init_q[set_full[SA-1:0]];
      end
      if (wr_en) begin
        row_init_q[set_q] <= 1'b1;
      end
    end
  end

  // Unpack the row; a row never written reads as empty.
  logic [NW-1:0][TAG_W-1:0] row_tag, new_tag;
  logic [NW-1:0]            row_valid, new_valid;
  logic [NW-1:0][AGE_W-1:0] row_age, new_age;
  logic                     hit;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      row_tag[w]   = rd_row_q[w*TAG_W +: TAG_W];
      row_valid[w] = rd_init_q & rd_row_q[NW*TAG_W + w];
      row_age[w]   = rd_init_q ? rd_row_q[NW*(TAG_W+1) + w*AGE_W +: AGE_W] : '0;
    end
  end

  salc_row_update #(
    .NW    (NW),
    .TAG_W (TAG_W)
  ) u_row_update (
    .tag_i       (tag_q),
    .inuse_i     (inuse),
    .row_tag_i   (row_tag),
    .row_valid_i (row_valid),
    .row_age_i   (row_age),
    .hit_o       (hit),
    .new_tag_o   (new_tag),
    .new_valid_o (new_valid),
    .new_age_o   (new_age)
  );

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      wr_row[w*TAG_W +: TAG_W]                = new_tag[w];
      wr_row[NW*TAG_W + w]                    = new_valid[w];
      wr_row[NW*(TAG_W+1) + w*AGE_W +: AGE_W] = new_age[w];
    end
  end

  // Output register.
  status_e              status_d;
  status_e              status_q;
  logic [SET_IDX_W-1:0] set_index_q;

  always_comb begin
    if (func_q == FUNC_STORE) begin
      status_d = ST_STORE;
    end else if (hit) begin
      status_d = ST_LOAD_HIT;
    end else begin
      status_d = ST_LOAD_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (look_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_done) begin
      status_q    <= status_d;
      set_index_q <= set_idx_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign set_index_o = set_index_q;

  // An accepted item always moves on to the update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_LOOK))
    else $error("accepted item did not enter the update cycle");

  // A new result only appears right after an update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_LOOK))
    else $error("result appeared without an update cycle");

  // A written row is marked initialized from then on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> row_init_q[$past(set_q)])
    else $error("written row not marked initialized");

  // Row write-back never overlaps with a new row read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("row read and write-back in the same cycle");

endmodule
